// ===== hw/rtl/arm_dp_alu_with_flags_unit_assert.svh =====
// assertion macros shared by the arm data-processing alu rtl
// no dependencies; include by bare file name inside a module body
`ifndef ARM_DP_ALU_WITH_FLAGS_UNIT_ASSERT_SVH
`define ARM_DP_ALU_WITH_FLAGS_UNIT_ASSERT_SVH

// clocked check, masked while reset is asserted
`define ARMDP_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds while reset is asserted
`define ARMDP_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/armdp_pkg.sv =====
// types and codes of the arm data-processing alu
// used by armdp_cond, armdp_alu and arm_dp_alu_with_flags_unit
package armdp_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned InDataW  = 80;  // 74 field bits padded to bytes
  localparam int unsigned OutDataW = 40;  // 38 field bits padded to bytes

  // arm condition codes
  typedef enum logic [3:0] {
    COND_EQ = 4'd0,  COND_NE = 4'd1,  COND_CS = 4'd2,  COND_CC = 4'd3,
    COND_MI = 4'd4,  COND_PL = 4'd5,  COND_VS = 4'd6,  COND_VC = 4'd7,
    COND_HI = 4'd8,  COND_LS = 4'd9,  COND_GE = 4'd10, COND_LT = 4'd11,
    COND_GT = 4'd12, COND_LE = 4'd13, COND_AL = 4'd14, COND_NV = 4'd15
  } cond_e;

  // data-processing opcodes in encoding order
  typedef enum logic [3:0] {
    OP_AND = 4'd0,  OP_EOR = 4'd1,  OP_SUB = 4'd2,  OP_RSB = 4'd3,
    OP_ADD = 4'd4,  OP_ADC = 4'd5,  OP_SBC = 4'd6,  OP_RSC = 4'd7,
    OP_TST = 4'd8,  OP_TEQ = 4'd9,  OP_CMP = 4'd10, OP_CMN = 4'd11,
    OP_ORR = 4'd12, OP_MOV = 4'd13, OP_BIC = 4'd14, OP_MVN = 4'd15
  } alu_op_e;

  // condition flags, packed as n z c v from msb down
  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } nzcv_t;

  // one result item as it leaves the alu
  typedef struct packed {
    nzcv_t              flags;
    logic               executed;
    logic               writes_dest;
    logic [DataW-1:0]   result;
  } alu_res_t;

endpackage

// ===== hw/rtl/armdp_cond.sv =====
// condition code check against the current nzcv flags
// depends on armdp_pkg
module armdp_cond (
  input  armdp_pkg::cond_e cond_i,
  input  armdp_pkg::nzcv_t flags_i,
  output logic             pass_o
);
  import armdp_pkg::*;

  // evaluate the condition
  always_comb begin
    unique case (cond_i)
      COND_EQ: pass_o = flags_i.z;
      COND_NE: pass_o = !flags_i.z;
      COND_CS: pass_o = flags_i.c;
      COND_CC: pass_o = !flags_i.c;
      COND_MI: pass_o = flags_i.n;
      COND_PL: pass_o = !flags_i.n;
      COND_VS: pass_o = flags_i.v;
      COND_VC: pass_o = !flags_i.v;
      COND_HI: pass_o = flags_i.c && !flags_i.z;
      COND_LS: pass_o = !flags_i.c || flags_i.z;
      COND_GE: pass_o = (flags_i.n == flags_i.v);
      COND_LT: pass_o = (flags_i.n != flags_i.v);
      COND_GT: pass_o = !flags_i.z && (flags_i.n == flags_i.v);
      COND_LE: pass_o = flags_i.z || (flags_i.n != flags_i.v);
      COND_AL: pass_o = 1'b1;
      COND_NV: pass_o = 1'b0;
      default: pass_o = 1'b0;
    endcase
  end

endmodule

// ===== hw/rtl/armdp_alu.sv =====
// data-processing datapath: operand select, 32-bit adder, logic ops, flags
// depends on armdp_pkg
module armdp_alu (
  input  armdp_pkg::alu_op_e  op_i,
  input  logic                set_flags_i,
  input  logic [31:0]         operand_a_i,
  input  logic [31:0]         operand_b_i,
  input  logic                shifter_carry_i,
  input  logic                exec_i,
  input  armdp_pkg::nzcv_t    flags_i,
  output armdp_pkg::alu_res_t res_o
);
  import armdp_pkg::*;

  logic [DataW-1:0] add_x, add_y, add_r, logic_r, res_r;
  logic             add_cin, arith, writes;
  logic [DataW:0]   add_sum;
  logic             add_c, add_v;
  nzcv_t            new_flags;

  // adder operand select
  always_comb begin
    add_x   = operand_a_i;
    add_y   = operand_b_i;
    add_cin = 1'b0;
    arith   = 1'b1;
    unique case (op_i)
      OP_SUB, OP_CMP: begin
        add_y   = ~operand_b_i;
        add_cin = 1'b1;
      end
      OP_RSB: begin
        add_x   = operand_b_i;
        add_y   = ~operand_a_i;
        add_cin = 1'b1;
      end
      OP_ADD, OP_CMN: begin
        add_cin = 1'b0;
      end
      OP_ADC: begin
        add_cin = flags_i.c;
      end
      OP_SBC: begin
        add_y   = ~operand_b_i;
        add_cin = flags_i.c;
      end
      OP_RSC: begin
        add_x   = operand_b_i;
        add_y   = ~operand_a_i;
        add_cin = flags_i.c;
      end
      default: begin
        arith = 1'b0;
      end
    endcase
  end

  // adder with carry out and signed overflow
  assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{DataW{1'b0}}, add_cin};
  assign add_r   = add_sum[DataW-1:0];
  assign add_c   = add_sum[DataW];
  assign add_v   = (add_x[DataW-1] ^ add_r[DataW-1]) & (add_y[DataW-1] ^ add_r[DataW-1]);

  // logical ops
  always_comb begin
    unique case (op_i)
      OP_AND, OP_TST: logic_r = operand_a_i & operand_b_i;
      OP_EOR, OP_TEQ: logic_r = operand_a_i ^ operand_b_i;
      OP_ORR:         logic_r = operand_a_i | operand_b_i;
      OP_MOV:         logic_r = operand_b_i;
      OP_BIC:         logic_r = operand_a_i & ~operand_b_i;
      default:        logic_r = ~operand_b_i;
    endcase
  end

  assign res_r  = arith ? add_r : logic_r;
  assign writes = !((op_i == OP_TST) || (op_i == OP_TEQ) ||
                    (op_i == OP_CMP) || (op_i == OP_CMN));

  // flag update
  always_comb begin
    new_flags = flags_i;
    if (exec_i && set_flags_i) begin
      new_flags.n = res_r[DataW-1];
      new_flags.z = (res_r == '0);
      if (arith) begin
        new_flags.c = add_c;
        new_flags.v = add_v;
      end else begin
        new_flags.c = shifter_carry_i;
      end
    end
  end

  // result item
  always_comb begin
    res_o.flags       = new_flags;
    res_o.executed    = exec_i;
    res_o.writes_dest = exec_i && writes;
    res_o.result      = exec_i ? res_r : '0;
  end

endmodule

// ===== hw/rtl/arm_dp_alu_with_flags_unit.sv =====
// arm data-processing alu with nzcv flags: one instruction per item, one
// result item per input item. an accepted item sits in the input register;
// once the result register is free or drained it passes through the
// condition check and alu into the result register while the flags register
// is updated at the same edge. throughput is one item per cycle while the
// output is not stalled; output valid rises when an item moves into the
// result register. the flag feedback loops through the flags register, so
// each item sees the flags left by the item just before it.
// depends on armdp_pkg, armdp_cond, armdp_alu, arm_dp_alu_with_flags_unit_assert.svh
module arm_dp_alu_with_flags_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // cond[3:0] opcode[7:4] set_flags[8] operand_a[40:9] operand_b[72:41]
  // shifter_carry[73], zero pad [79:74]
  input  logic [armdp_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // result[31:0] writes_dest[32] executed[33] flags_out[37:34] (n z c v
  // from bit 37 down), zero pad [39:38]
  output logic [armdp_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import armdp_pkg::*;
  `include "arm_dp_alu_with_flags_unit_assert.svh"

  logic        in_valid_q, out_valid_q;
  logic        advance;
  cond_e       cond_q;
  alu_op_e     op_q;
  logic        set_flags_q, shifter_carry_q;
  logic [31:0] operand_a_q, operand_b_q;
  nzcv_t       flags_q, flags_d;
  alu_res_t    alu_res, out_q;
  logic        cond_pass;

  // handshake: an item moves on when the result register is free or drained
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - $bits(alu_res_t)){1'b0}}, out_q};

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      cond_q          <= cond_e'(s_axis_tdata_i[3:0]);
      op_q            <= alu_op_e'(s_axis_tdata_i[7:4]);
      set_flags_q     <= s_axis_tdata_i[8];
      operand_a_q     <= s_axis_tdata_i[40:9];
      operand_b_q     <= s_axis_tdata_i[72:41];
      shifter_carry_q <= s_axis_tdata_i[73];
    end
  end

  armdp_cond u_cond (
    .cond_i  (cond_q),
    .flags_i (flags_q),
    .pass_o  (cond_pass)
  );

  armdp_alu u_alu (
    .op_i            (op_q),
    .set_flags_i     (set_flags_q),
    .operand_a_i     (operand_a_q),
    .operand_b_i     (operand_b_q),
    .shifter_carry_i (shifter_carry_q),
    .exec_i          (cond_pass),
    .flags_i         (flags_q),
    .res_o           (alu_res)
  );

  // flags follow the item that moves into the result register
  assign flags_d = advance ? alu_res.flags : flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      flags_q <= flags_d;
      if (!out_valid_q || m_axis_tready_i) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= alu_res;
    end
  end

  // flags hold unless an item moves to the result register
  `ARMDP_ASSERT(a_flags_hold, clk_i, rst_ni, !advance |=> $stable(flags_q), "flags changed without an item")
  // a shown item carries the current flags
  `ARMDP_ASSERT(a_flags_shown, clk_i, rst_ni, out_valid_q |-> (out_q.flags == flags_q), "item flags differ from flags register")
  // no destination write without execution
  `ARMDP_ASSERT(a_write_exec, clk_i, rst_ni, (out_valid_q && out_q.writes_dest) |-> out_q.executed, "write without execution")
  // a skipped item carries a zero result
  `ARMDP_ASSERT(a_skip_zero, clk_i, rst_ni, (out_valid_q && !out_q.executed) |-> (out_q.result == '0), "skipped item with nonzero result")
  // nothing is offered while in reset
  `ARMDP_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !m_axis_tvalid_o, "output valid during reset")

endmodule

// ===== tb/sv/arm_dp_alu_with_flags_unit_tb.sv =====
// self-checking testbench for the arm data-processing alu with nzcv flags
// directed table then random items, checked against hand-written rows or an in-bench predictor
// depends on armdp_pkg and the arm_dp_alu_with_flags_unit rtl
module arm_dp_alu_with_flags_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import armdp_pkg::*;

  localparam int unsigned RandItems  = 1000;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 8;
  localparam int unsigned MaxShown   = 10;

  // one input item, cond in the lowest bits
  typedef struct packed {
    logic             shifter_carry;
    logic [DataW-1:0] operand_b;
    logic [DataW-1:0] operand_a;
    logic             set_flags;
    alu_op_e          opcode;
    cond_e            cond;
  } dp_item_t;

  localparam int unsigned ItemW = $bits(dp_item_t);

  // hand-written expectation attached to an item
  typedef struct packed {
    logic     chk;
    alu_res_t want;
  } typed_exp_t;

  // one row of the directed table
  typedef struct packed {
    dp_item_t item;
    logic     chk;
    alu_res_t want;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  nzcv_t        model_flags = '0;
  alu_res_t     alu_res_q[$];
  typed_exp_t   typed_q[$];
  stim_row_t    dir_tbl[$];
  int unsigned  err_cnt = 0;
  int unsigned  cyc_cnt = 0;
  int unsigned  burst_left = 0;
  int unsigned  stall_left = 0;
  int unsigned  stall_mode = 0;

  arm_dp_alu_with_flags_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  // clock
  always #1 clk_i = ~clk_i;

  // predict one instruction and advance the kept flags
  function automatic alu_res_t alu_predict(input dp_item_t it);
    logic [DataW:0]   sum;
    logic [DataW-1:0] x, y, r;
    logic             cin, arith, pass, c, v;
    nzcv_t            f, nf;
    alu_res_t         res;
    f     = model_flags;
    r     = '0;
    x     = '0;
    y     = '0;
    cin   = 1'b0;
    arith = 1'b0;
    case (it.cond)
      COND_EQ: pass = f.z;
      COND_NE: pass = !f.z;
      COND_CS: pass = f.c;
      COND_CC: pass = !f.c;
      COND_MI: pass = f.n;
      COND_PL: pass = !f.n;
      COND_VS: pass = f.v;
      COND_VC: pass = !f.v;
      COND_HI: pass = f.c && !f.z;
      COND_LS: pass = !f.c || f.z;
      COND_GE: pass = (f.n == f.v);
      COND_LT: pass = (f.n != f.v);
      COND_GT: pass = !f.z && (f.n == f.v);
      COND_LE: pass = f.z || (f.n != f.v);
      COND_AL: pass = 1'b1;
      default: pass = 1'b0;
    endcase
    // adder operands for the arithmetic group
    case (it.opcode)
      OP_SUB, OP_CMP: begin x = it.operand_a; y = ~it.operand_b; cin = 1'b1; arith = 1'b1; end
      OP_RSB:         begin x = it.operand_b; y = ~it.operand_a; cin = 1'b1; arith = 1'b1; end
      OP_ADD, OP_CMN: begin x = it.operand_a; y = it.operand_b;  cin = 1'b0; arith = 1'b1; end
      OP_ADC:         begin x = it.operand_a; y = it.operand_b;  cin = f.c;  arith = 1'b1; end
      OP_SBC:         begin x = it.operand_a; y = ~it.operand_b; cin = f.c;  arith = 1'b1; end
      OP_RSC:         begin x = it.operand_b; y = ~it.operand_a; cin = f.c;  arith = 1'b1; end
      default: ;
    endcase
    sum = {1'b0, x} + {1'b0, y} + {{DataW{1'b0}}, cin};
    c   = sum[DataW];
    v   = (x[DataW-1] ^ sum[DataW-1]) & (y[DataW-1] ^ sum[DataW-1]);
    // logical group
    case (it.opcode)
      OP_AND, OP_TST: r = it.operand_a & it.operand_b;
      OP_EOR, OP_TEQ: r = it.operand_a ^ it.operand_b;
      OP_ORR:         r = it.operand_a | it.operand_b;
      OP_MOV:         r = it.operand_b;
      OP_BIC:         r = it.operand_a & ~it.operand_b;
      OP_MVN:         r = ~it.operand_b;
      default:        r = sum[DataW-1:0];
    endcase
    res.writes_dest = 1'b0;
    res.executed    = pass;
    if (!pass) begin
      r = '0;
    end else begin
      res.writes_dest = !(it.opcode inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN});
      if (it.set_flags) begin
        nf.n = r[DataW-1];
        nf.z = (r == '0);
        nf.c = arith ? c : it.shifter_carry;
        nf.v = arith ? v : f.v;
        model_flags = nf;
      end
    end
    res.result = r;
    res.flags  = model_flags;
    return res;
  endfunction

  // operand mix: corner values and plain random words
  function automatic logic [DataW-1:0] rand_operand();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h7fff_ffff;
      4:       return DataW'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  function automatic dp_item_t rand_item();
    dp_item_t it;
    it.cond          = ($urandom_range(0, 9) < 4) ? COND_AL : cond_e'($urandom_range(0, 15));
    it.opcode        = alu_op_e'($urandom_range(0, 15));
    it.set_flags     = ($urandom_range(0, 3) != 0);
    it.operand_a     = rand_operand();
    it.operand_b     = rand_operand();
    it.shifter_carry = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic add_row(input cond_e cd, input alu_op_e op, input logic s,
                         input logic [DataW-1:0] a, input logic [DataW-1:0] b,
                         input logic sc, input logic chk, input alu_res_t want);
    stim_row_t row;
    row.item = '{shifter_carry: sc, operand_b: b, operand_a: a, set_flags: s,
                 opcode: op, cond: cd};
    row.chk  = chk;
    row.want = want;
    dir_tbl.push_back(row);
  endtask

  // present one item, hold until accepted, then maybe open a gap
  task automatic send_item(input dp_item_t it, input logic chk, input alu_res_t want);
    typed_exp_t te;
    te.chk  = chk;
    te.want = want;
    typed_q.push_back(te);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW-ItemW){1'b0}}, it};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  // hold the sender until every expected result is out
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (alu_res_q.size() != 0) @(posedge clk_i);
  endtask

  // input side: predict each accepted item
  always @(posedge clk_i) begin : in_mon
    alu_res_t   p;
    typed_exp_t te;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      p  = alu_predict(dp_item_t'(s_axis_tdata[ItemW-1:0]));
      te = typed_q.pop_front();
      alu_res_q.push_back(te.chk ? te.want : p);
    end
  end

  // output side: compare against the oldest expectation
  always @(posedge clk_i) begin : out_mon
    alu_res_t got, w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = alu_res_t'(m_axis_tdata[$bits(alu_res_t)-1:0]);
      if (alu_res_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MaxShown)
          $display("[%0t] unexpected result item %h", $realtime, got);
      end else begin
        w = alu_res_q.pop_front();
        if (got.result !== w.result || got.writes_dest !== w.writes_dest ||
            got.executed !== w.executed || got.flags !== w.flags) begin
          err_cnt++;
          if (err_cnt <= MaxShown)
            $display("[%0t] mismatch: exp res=%h wd=%b ex=%b nzcv=%b got res=%h wd=%b ex=%b nzcv=%b",
                     $realtime, w.result, w.writes_dest, w.executed, w.flags,
                     got.result, got.writes_dest, got.executed, got.flags);
        end
      end
    end
  end

  // receiver stalls: free-running, random and sparse stretches
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= (cyc_cnt[1:0] == 2'b00);
    endcase
  end

  // run limit
  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    // assert reset with a real falling edge
    rst_ni <= 1'b0;

    // flags start at zero after reset
    add_row(COND_EQ, OP_ADD, 1'b1, 32'h0, 32'h0, 1'b0, 1'b1,
            '{nzcv_t'(4'b0000), 1'b0, 1'b0, 32'h0});
    add_row(COND_AL, OP_ADD, 1'b1, 32'h0, 32'h0, 1'b0, 1'b1,
            '{nzcv_t'(4'b0100), 1'b1, 1'b1, 32'h0});
    // never condition leaves everything alone
    add_row(COND_NV, OP_MOV, 1'b1, 32'h0, 32'hffff_ffff, 1'b1, 1'b1,
            '{nzcv_t'(4'b0100), 1'b0, 1'b0, 32'h0});
    add_row(COND_EQ, OP_MVN, 1'b1, 32'h0, 32'h0, 1'b1, 1'b1,
            '{nzcv_t'(4'b1010), 1'b1, 1'b1, 32'hffff_ffff});
    // unsigned wrap and signed overflow on add
    add_row(COND_AL, OP_ADD, 1'b1, 32'hffff_ffff, 32'h1, 1'b0, 1'b1,
            '{nzcv_t'(4'b0110), 1'b1, 1'b1, 32'h0});
    add_row(COND_AL, OP_ADD, 1'b1, 32'h7fff_ffff, 32'h1, 1'b0, 1'b1,
            '{nzcv_t'(4'b1001), 1'b1, 1'b1, 32'h8000_0000});
    // remaining ops and conditions, checked by the predictor
    add_row(COND_GE, OP_ADC, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 1'b0, '0);
    add_row(COND_LT, OP_SUB, 1'b1, 32'h0, 32'h1, 1'b0, 1'b0, '0);
    add_row(COND_AL, OP_SUB, 1'b1, 32'h5, 32'h5, 1'b0, 1'b0, '0);
    add_row(COND_CS, OP_RSB, 1'b1, 32'h1, 32'h0, 1'b0, 1'b0, '0);
    add_row(COND_CC, OP_SBC, 1'b1, 32'h0, 32'h0, 1'b0, 1'b0, '0);
    add_row(COND_HI, OP_RSC, 1'b1, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 1'b0, '0);
    add_row(COND_LS, OP_TST, 1'b1, 32'hf0f0_f0f0, 32'h0f0f_0f0f, 1'b1, 1'b0, '0);
    add_row(COND_MI, OP_TEQ, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 1'b0, '0);
    add_row(COND_PL, OP_CMP, 1'b1, 32'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b0, '0);
    add_row(COND_VC, OP_CMN, 1'b1, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, '0);
    add_row(COND_VS, OP_ORR, 1'b0, 32'h1234_5678, 32'h8765_4321, 1'b1, 1'b0, '0);
    add_row(COND_GT, OP_AND, 1'b1, 32'hffff_ffff, 32'h8000_0000, 1'b0, 1'b0, '0);
    add_row(COND_LE, OP_EOR, 1'b1, 32'haaaa_aaaa, 32'h5555_5555, 1'b0, 1'b0, '0);
    add_row(COND_NE, OP_BIC, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b0, '0);
    add_row(COND_AL, OP_MOV, 1'b0, 32'h0, 32'hdead_beef, 1'b0, 1'b0, '0);
    add_row(COND_AL, OP_SBC, 1'b1, 32'h8000_0000, 32'h1, 1'b0, 1'b0, '0);
    add_row(COND_AL, OP_RSC, 1'b1, 32'h0, 32'h0, 1'b1, 1'b0, '0);

    // reset
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_tbl[i]) send_item(dir_tbl[i].item, dir_tbl[i].chk, dir_tbl[i].want);
    drain_results();

    // random items, with one full drain halfway
    burst_left = $urandom_range(0, 40);
    for (int unsigned n = 0; n < RandItems; n++) begin
      if (n == RandItems / 2) drain_results();
      send_item(rand_item(), 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    // wait out the remaining results
    while (alu_res_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/armdp_pkg.sv
hw/rtl/armdp_cond.sv
hw/rtl/armdp_alu.sv
hw/rtl/arm_dp_alu_with_flags_unit.sv
tb/sv/arm_dp_alu_with_flags_unit_tb.sv
